FILE: rtl/xee_pkg.sv
`default_nettype none
package xee_pkg;

	localparam int BudgetW = 10;
	localparam logic [BudgetW-1:0] BUDGET_RESET = 10'd100;

	// source bytes with special handling
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_SLASH = 8'h2f;

	// entity strings, first character in the top byte
	localparam logic [47:0] STR_AMP  = {"&amp;", 8'h00};
	localparam logic [47:0] STR_LT   = {"&lt;", 16'h0000};
	localparam logic [47:0] STR_GT   = {"&gt;", 16'h0000};
	localparam logic [47:0] STR_QUOT = "&quot;";
	localparam logic [47:0] STR_APOS = "&apos;";

	typedef enum logic [2:0] {
		ENT_NONE = 3'd0,
		ENT_AMP  = 3'd1,
		ENT_LT   = 3'd2,
		ENT_GT   = 3'd3,
		ENT_QUOT = 3'd4,
		ENT_APOS = 3'd5
	} ent_sel_t;

	// one item's worth of results, as handed from control to the emitter
	typedef struct packed {
		ent_sel_t            sel;
		logic [7:0]          lit;
		logic                done;
		logic [BudgetW-1:0]  count;
	} desc_t;

	function automatic logic [2:0] ent_len(input ent_sel_t sel);
		logic [2:0] len;
		unique case (sel)
			ENT_AMP:  len = 3'd5;
			ENT_LT:   len = 3'd4;
			ENT_GT:   len = 3'd4;
			ENT_QUOT: len = 3'd6;
			ENT_APOS: len = 3'd6;
			default:  len = 3'd1;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] ent_char(input ent_sel_t sel, input logic [2:0] idx);
		logic [47:0] str;
		logic [7:0]  ch;
		unique case (sel)
			ENT_AMP:  str = STR_AMP;
			ENT_LT:   str = STR_LT;
			ENT_GT:   str = STR_GT;
			ENT_QUOT: str = STR_QUOT;
			ENT_APOS: str = STR_APOS;
			default:  str = '0;
		endcase
		unique case (idx)
			3'd0:    ch = str[47:40];
			3'd1:    ch = str[39:32];
			3'd2:    ch = str[31:24];
			3'd3:    ch = str[23:16];
			3'd4:    ch = str[15:8];
			3'd5:    ch = str[7:0];
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/xee_ctrl.sv
`default_nettype none
module xee_ctrl
	import xee_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [BudgetW-1:0] cfg_data,
	input  wire logic               in_acc,
	input  wire logic [7:0]         in_char,
	output logic                    desc_valid,
	output desc_t                   desc
);

	logic [BudgetW-1:0] budget_q;
	logic [BudgetW-1:0] space_q;
	logic               halted_q;

	logic [BudgetW-1:0] space_d;
	logic               halted_d;
	logic               emit;
	ent_sel_t           sel;
	logic [2:0]         len;

	assign cfg_ready = 1'b1;

	always_comb begin
		unique case (in_char)
			CH_AMP:  sel = ENT_AMP;
			CH_LT:   sel = ENT_LT;
			CH_GT:   sel = ENT_GT;
			CH_QUOT: sel = ENT_QUOT;
			CH_APOS: sel = ENT_APOS;
			default: sel = ENT_NONE;
		endcase
		len = ent_len(sel);
	end

	always_comb begin
		emit       = 1'b0;
		space_d    = space_q;
		halted_d   = halted_q;
		desc.sel   = ENT_NONE;
		desc.lit   = (in_char == CH_BSL) ? CH_SLASH : in_char;
		desc.done  = 1'b0;
		desc.count = '0;
		priority if (in_char == CH_NUL) begin
			emit       = 1'b1;
			desc.lit   = CH_NUL;
			desc.done  = 1'b1;
			desc.count = budget_q - space_q;
			space_d    = budget_q;
			halted_d   = 1'b0;
		end else if (halted_q || space_q == '0) begin
			emit = 1'b0;
		end else if (sel == ENT_NONE) begin
			emit    = 1'b1;
			space_d = space_q - BudgetW'(1);
		end else if (space_q > BudgetW'(len)) begin
			emit     = 1'b1;
			desc.sel = sel;
			space_d  = space_q - BudgetW'(len);
		end else begin
			// entity does not fit: drop the rest of the string
			halted_d = 1'b1;
		end
	end

	assign desc_valid = in_acc && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BUDGET_RESET;
			space_q  <= BUDGET_RESET;
			halted_q <= 1'b0;
		end else if (cfg_valid) begin
			budget_q <= cfg_data;
			space_q  <= cfg_data;
			halted_q <= 1'b0;
		end else if (in_acc) begin
			space_q  <= space_d;
			halted_q <= halted_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/xee_emit.sv
`default_nettype none
module xee_emit
	import xee_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               desc_valid,
	input  wire desc_t              desc,
	output logic                    free,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [7:0]              out_byte,
	output logic                    run_last,
	output logic                    string_done,
	output logic [BudgetW-1:0]      bytes_written
);

	logic       s1_valid_q;
	desc_t      s1_q;
	logic [2:0] idx_q;
	logic       s2_valid_q;
	logic       load;
	logic       last1;
	logic [7:0] byte1;

	assign last1 = (idx_q == ent_len(s1_q.sel) - 3'd1);
	assign byte1 = (s1_q.sel == ENT_NONE) ? s1_q.lit : ent_char(s1_q.sel, idx_q);
	assign load  = s1_valid_q && (!s2_valid_q || out_ready);
	// the held item leaves with its last byte, so the next one can take its place
	assign free  = !s1_valid_q || (load && last1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			idx_q      <= '0;
			s2_valid_q <= 1'b0;
		end else begin
			if (desc_valid) begin
				s1_valid_q <= 1'b1;
			end else if (load && last1) begin
				s1_valid_q <= 1'b0;
			end
			if (load) begin
				idx_q <= last1 ? 3'd0 : idx_q + 3'd1;
			end
			if (load) begin
				s2_valid_q <= 1'b1;
			end else if (out_ready) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (desc_valid) begin
			s1_q <= desc;
		end
		if (load) begin
			out_byte      <= byte1;
			run_last      <= last1;
			string_done   <= s1_q.done;
			bytes_written <= s1_q.count;
		end
	end

	assign out_valid = s2_valid_q;

endmodule
`default_nettype wire

FILE: rtl/xml_escape_encoder_core.sv
// an accepted item waits in the item register, its bytes leave via the output register
// throughput: one item per cycle for plain bytes and terminators unless the output stalls;
// an entity holds the input until its last byte is loaded into the one-byte output register
// items dropped after the space runs out are accepted and give no result
// reset: budget and space left load 100, halt flag clears, pipeline empties
`default_nettype none
module xml_escape_encoder_core
	import xee_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [7:0]         s_tdata,   // [7:0] char_byte
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [23:0]             m_tdata,   // [7:0] out_byte, [17:8] bytes_written, zero pad
	output logic                    m_tlast,   // run_last
	output logic                    m_tuser,   // string_done
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [BudgetW-1:0] cfg_data
);

	logic               in_acc;
	logic               free;
	logic               desc_valid;
	desc_t              desc;
	logic [7:0]         out_byte;
	logic [BudgetW-1:0] bytes_written;

	assign s_tready = free;
	assign in_acc   = s_tvalid && free;

	xee_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_acc     (in_acc),
		.in_char    (s_tdata),
		.desc_valid (desc_valid),
		.desc       (desc)
	);

	xee_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.desc_valid    (desc_valid),
		.desc          (desc),
		.free          (free),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_byte      (out_byte),
		.run_last      (m_tlast),
		.string_done   (m_tuser),
		.bytes_written (bytes_written)
	);

	assign m_tdata = {6'b0, bytes_written, out_byte};

	// a terminator is always the only result of its item
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("terminator without run_last");

	// only a terminator carries a byte count
	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[17:8] == 10'd0)
		else $error("byte count on a data result");

	// terminator carries a zero byte
	a_done_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[7:0] == 8'h00)
		else $error("terminator byte not zero");

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`default_nettype none
module testbench;
	import xee_pkg::*;

	typedef struct packed {
		logic [7:0]         ch;
		logic               last;
		logic               done;
		logic [BudgetW-1:0] count;
	} out_byte_t;

	// predicts the escaped byte stream and holds what is still owed by the block
	class escape_checker;
		logic [BudgetW-1:0] budget;
		logic [BudgetW-1:0] space_left;
		bit                 halted;
		out_byte_t          owed_bytes[$];
		int                 errors;

		function new();
			budget = BUDGET_RESET;
			space_left = BUDGET_RESET;
			halted = 1'b0;
			errors = 0;
		endfunction

		function void set_budget(logic [BudgetW-1:0] value);
			budget = value;
			space_left = value;
			halted = 1'b0;
		endfunction

		function void owe(logic [7:0] ch, logic last, logic done, logic [BudgetW-1:0] count);
			out_byte_t r;
			r.ch = ch;
			r.last = last;
			r.done = done;
			r.count = count;
			owed_bytes.push_back(r);
		endfunction

		function void note_char(logic [7:0] c);
			string ent;
			ent = "";
			if (c == CH_NUL) begin
				owe(8'h00, 1'b1, 1'b1, budget - space_left);
				space_left = budget;
				halted = 1'b0;
				return;
			end
			// nothing more for this string once it has stopped
			if (halted || space_left == '0)
				return;
			case (c)
				CH_AMP:  ent = "&amp;";
				CH_LT:   ent = "&lt;";
				CH_GT:   ent = "&gt;";
				CH_QUOT: ent = "&quot;";
				CH_APOS: ent = "&apos;";
				default: ent = "";
			endcase
			if (ent.len() == 0) begin
				owe((c == CH_BSL) ? CH_SLASH : c, 1'b1, 1'b0, '0);
				space_left = space_left - 1'b1;
			end else if (space_left <= ent.len()) begin
				halted = 1'b1;
			end else begin
				for (int i = 0; i < ent.len(); i++)
					owe(ent[i], i == ent.len() - 1, 1'b0, '0);
				space_left = space_left - BudgetW'(ent.len());
			end
		endfunction

		function void check_output(logic [7:0] ch, logic last, logic done,
				logic [BudgetW-1:0] count);
			out_byte_t w;
			if (owed_bytes.size() == 0) begin
				$display("%0t: unexpected item: expected none, %s %h last %b done %b count %0d",
					$time, "actual byte", ch, last, done, count);
				errors++;
				return;
			end
			w = owed_bytes.pop_front();
			if (ch !== w.ch) begin
				$display("%0t: out_byte: expected %h, actual %h", $time, w.ch, ch);
				errors++;
			end
			if (last !== w.last) begin
				$display("%0t: run_last: expected %b, actual %b", $time, w.last, last);
				errors++;
			end
			if (done !== w.done) begin
				$display("%0t: string_done: expected %b, actual %b", $time, w.done, done);
				errors++;
			end
			if (count !== w.count) begin
				$display("%0t: bytes_written: expected %0d, actual %0d", $time, w.count, count);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [23:0]        m_tdata;
	logic               m_tlast;
	logic               m_tuser;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [BudgetW-1:0] cfg_data;

	bit tx_idle;
	bit rx_idle;
	escape_checker sb = new();

	xml_escape_encoder_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// leaves tvalid high after the handshake so a zero gap keeps the stream going
	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = tx_idle ? $urandom_range(0, 16) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		do @(posedge clk); while (!s_tready);
		sb.note_char(c);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.owed_bytes.size() != 0);
	endtask

	task automatic write_budget(input logic [BudgetW-1:0] value);
		drain_results();
		// dropped items give no result, so let the pipeline empty
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_budget(value);
	endtask

	function automatic logic [7:0] random_char();
		if ($urandom_range(0, 9) < 4) begin
			case ($urandom_range(0, 5))
				0:       return CH_AMP;
				1:       return CH_LT;
				2:       return CH_GT;
				3:       return CH_QUOT;
				4:       return CH_APOS;
				default: return CH_BSL;
			endcase
		end
		return 8'($urandom_range(1, 255));
	endfunction

	task automatic random_phase(input logic [BudgetW-1:0] budget_val, input int n_items);
		int sent;
		int len;
		sent = 0;
		write_budget(budget_val);
		tx_idle = $urandom_range(0, 3) != 0;
		rx_idle = $urandom_range(0, 3) != 0;
		while (sent < n_items) begin
			len = $urandom_range(0, 16);
			for (int k = 0; k < len; k++) begin
				send_char(random_char());
				sent++;
				// sender holds off mid-string until the output side has caught up
				if ($urandom_range(0, 39) == 0)
					drain_results();
			end
			send_char(CH_NUL);
			sent++;
		end
	endtask

	// output side
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_idle ? $urandom_range(0, 16) : 0;
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_output(m_tdata[7:0], m_tlast, m_tuser, m_tdata[17:8]);
		end
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		m_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every escape and plain-byte extremes at the reset budget, back to back
		send_text("a&b<c>d\"e'f\\");
		send_char(8'hff);
		send_char(8'h01);
		send_char(CH_NUL);
		// empty string
		send_char(CH_NUL);

		tx_idle = 1'b1;
		rx_idle = 1'b1;
		// smallest budget: one byte out, the rest dropped
		write_budget(10'd1);
		send_text("xy");
		send_char(CH_NUL);
		// entity that does not fit halts the string, later bytes are dropped
		write_budget(10'd6);
		send_text("\"q");
		send_char(CH_NUL);
		// entity that just fits, then space runs out
		send_text("&b<");
		send_char(CH_NUL);

		random_phase(10'd1023, 33);
		random_phase(10'd1, 33);
		random_phase(10'd7, 33);
		random_phase(10'd5, 33);
		random_phase(10'd12, 33);
		random_phase(10'd40, 33);
		random_phase(10'($urandom_range(1, 1023)), 33);
		random_phase(10'd3, 33);
		random_phase(10'd6, 33);
		random_phase(10'd100, 33);

		drain_results();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.owed_bytes.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/xee_pkg.sv
rtl/xee_ctrl.sv
rtl/xee_emit.sv
rtl/xml_escape_encoder_core.sv
verif/testbench.sv
